// ===== hdl/hvb_pkg.sv =====
package hvb_pkg;

  typedef enum logic [1:0] {
    OP_ALPHA_ONE  = 2'd0,
    OP_ALPHA_IN   = 2'd1,
    OP_ALPHA_LOW  = 2'd2,
    OP_TIMES_FOUR = 2'd3
  } opcode_t;

  localparam logic [7:0] GAIN_RESET = 8'd22;
  localparam int unsigned NUM_CELLS = 8;

  typedef struct packed {
    logic [7:0]  alpha;
    logic        gray;
    logic [15:0] prod;
    logic [15:0] rem_s;
    logic [15:0] dsh_s;
    logic [7:0]  q_s;
    logic [18:0] rem_h;
    logic [18:0] dsh_h;
    logic [7:0]  q_h;
  } div_word_t;

endpackage

// ===== hdl/hvb_if.sv =====
interface hvb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] color_word;
  logic [7:0]  alpha_in;
  modport source(output valid, opcode, color_word, alpha_in, input ready);
  modport sink(input valid, opcode, color_word, alpha_in, output ready);
endinterface

interface hvb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_alpha;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  modport source(output valid, out_alpha, out_red, out_green, out_blue, input ready);
  modport sink(input valid, out_alpha, out_red, out_green, out_blue, output ready);
endinterface

// ===== hdl/hvb_front.sv =====
module hvb_front (
  input  logic                clk,
  input  logic                rst,
  hvb_in_if.sink              src,
  input  logic [7:0]          gain,
  output logic                dn_valid,
  input  logic                dn_ready,
  output hvb_pkg::div_word_t  dn_word
);
  import hvb_pkg::*;

  logic [7:0]         r8, g8, b8, mx, mn, d, alpha;
  logic [11:0]        d6;
  logic signed [11:0] sr, sg, sb, sd, six;
  div_word_t          word_next;

  always_comb begin
    if (opcode_t'(src.opcode) == OP_TIMES_FOUR) begin
      r8 = {src.color_word[29:24], 2'b00};
      g8 = {src.color_word[21:16], 2'b00};
      b8 = {src.color_word[13:8], 2'b00};
    end else begin
      r8 = src.color_word[31:24];
      g8 = src.color_word[23:16];
      b8 = src.color_word[15:8];
    end
    unique case (opcode_t'(src.opcode))
      OP_ALPHA_IN:  alpha = src.alpha_in;
      OP_ALPHA_LOW: alpha = src.color_word[7:0];
      default:      alpha = 8'hFF;
    endcase
    mx = r8;
    mn = r8;
    if (g8 > mx) mx = g8;
    if (b8 > mx) mx = b8;
    if (g8 < mn) mn = g8;
    if (b8 < mn) mn = b8;
    d  = mx - mn;
    d6 = 12'(d) * 12'd6;
    sr = $signed({4'b0000, r8});
    sg = $signed({4'b0000, g8});
    sb = $signed({4'b0000, b8});
    sd = $signed({4'b0000, d});
    if (r8 == mx) begin
      six = sg - sb;
      if (six < 0) six = six + $signed(d6);
    end else if (g8 == mx) begin
      six = (sd <<< 1) + sb - sr;
    end else begin
      six = (sd <<< 2) + sr - sg;
    end
    word_next.alpha = alpha;
    word_next.gray  = (d == 8'd0);
    word_next.prod  = 16'(mx) * 16'(gain);
    word_next.rem_s = 16'(d) * 16'd255;
    word_next.dsh_s = 16'(mx) << 7;
    word_next.q_s   = 8'd0;
    word_next.rem_h = 19'(six[10:0]) * 19'd255;
    word_next.dsh_h = 19'(d6) << 7;
    word_next.q_h   = 8'd0;
  end

  assign src.ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (src.ready) begin
      dn_valid <= src.valid;
    end
    if (src.ready && src.valid) begin
      dn_word <= word_next;
    end
  end
endmodule

// ===== hdl/hvb_div_cell.sv =====
module hvb_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  hvb_pkg::div_word_t  up_word,
  output logic                dn_valid,
  input  logic                dn_ready,
  output hvb_pkg::div_word_t  dn_word
);
  import hvb_pkg::*;

  div_word_t word_next;
  logic      bit_s, bit_h;

  always_comb begin
    word_next = up_word;
    bit_s = up_word.rem_s >= up_word.dsh_s;
    bit_h = up_word.rem_h >= up_word.dsh_h;
    if (bit_s) word_next.rem_s = up_word.rem_s - up_word.dsh_s;
    if (bit_h) word_next.rem_h = up_word.rem_h - up_word.dsh_h;
    word_next.q_s   = {up_word.q_s[6:0], bit_s};
    word_next.q_h   = {up_word.q_h[6:0], bit_h};
    word_next.dsh_s = up_word.dsh_s >> 1;
    word_next.dsh_h = up_word.dsh_h >> 1;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_word <= word_next;
    end
  end
endmodule

// ===== hdl/hvb_back.sv =====
module hvb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  hvb_pkg::div_word_t  up_word,
  hvb_out_if.source           dst
);
  import hvb_pkg::*;

  typedef struct packed {
    logic [7:0] alpha;
    logic       gray;
    logic [2:0] sec;
    logic [7:0] f;
    logic [7:0] s;
    logic [7:0] v;
  } st1_t;

  typedef struct packed {
    logic [7:0]  alpha;
    logic        gray;
    logic [2:0]  sec;
    logic [7:0]  v;
    logic [15:0] sf;
    logic [15:0] sfc;
    logic [15:0] lonum;
  } st2_t;

  typedef struct packed {
    logic [7:0]  alpha;
    logic        gray;
    logic [2:0]  sec;
    logic [7:0]  v;
    logic [23:0] xa;
    logic [23:0] xb;
    logic [7:0]  lo;
  } st3_t;

  typedef struct packed {
    logic [7:0]  alpha;
    logic        gray;
    logic [2:0]  sec;
    logic [7:0]  v;
    logic [7:0]  lo;
    logic [15:0] ta;
    logic [15:0] tb;
  } st4_t;

  logic [4:0] vld;
  logic [5:0] rdy;
  st1_t s1, s1_next;
  st2_t s2, s2_next;
  st3_t s3, s3_next;
  st4_t s4, s4_next;
  logic [7:0]  ro_next, go_next, bo_next, dn, up;
  logic [10:0] h6;
  logic [31:0] vm, lm, da, db;
  logic [55:0] pa, pb;
  logic [15:0] ya, yb;

  always_comb begin
    rdy[5] = dst.ready;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k + 1];
    end
  end
  assign up_ready = rdy[0];

  always_comb begin
    h6 = 11'(up_word.q_h) * 11'd6;
    if (h6 >= 11'd1275)      s1_next.sec = 3'd5;
    else if (h6 >= 11'd1020) s1_next.sec = 3'd4;
    else if (h6 >= 11'd765)  s1_next.sec = 3'd3;
    else if (h6 >= 11'd510)  s1_next.sec = 3'd2;
    else if (h6 >= 11'd255)  s1_next.sec = 3'd1;
    else                     s1_next.sec = 3'd0;
    s1_next.f     = 8'(h6 - 11'(s1_next.sec) * 11'd255);
    s1_next.alpha = up_word.alpha;
    s1_next.gray  = up_word.gray;
    s1_next.s     = up_word.q_s;
    vm = 32'(up_word.prod) * 32'h0000CCCD;
    s1_next.v = (up_word.prod >= 16'd2560) ? 8'd255 : vm[26:19];

    s2_next.alpha = s1.alpha;
    s2_next.gray  = s1.gray;
    s2_next.sec   = s1.sec;
    s2_next.v     = s1.v;
    s2_next.sf    = 16'(s1.s) * 16'(s1.f);
    s2_next.sfc   = 16'(s1.s) * 16'(8'd255 - s1.f);
    s2_next.lonum = 16'(s1.v) * 16'(8'd255 - s1.s);

    ya = 16'd65025 - s2.sf;
    yb = 16'd65025 - s2.sfc;
    lm = 32'(s2.lonum) * 32'h00008081;
    s3_next.alpha = s2.alpha;
    s3_next.gray  = s2.gray;
    s3_next.sec   = s2.sec;
    s3_next.v     = s2.v;
    s3_next.xa    = 24'(s2.v) * 24'(ya);
    s3_next.xb    = 24'(s2.v) * 24'(yb);
    s3_next.lo    = lm[30:23];

    pa = 56'(s3.xa) * 56'h0080808081;
    pb = 56'(s3.xb) * 56'h0080808081;
    s4_next.alpha = s3.alpha;
    s4_next.gray  = s3.gray;
    s4_next.sec   = s3.sec;
    s4_next.v     = s3.v;
    s4_next.lo    = s3.lo;
    s4_next.ta    = pa[54:39];
    s4_next.tb    = pb[54:39];

    da = 32'(s4.ta) * 32'h00008081;
    db = 32'(s4.tb) * 32'h00008081;
    dn = da[30:23];
    up = db[30:23];
    case (s4.sec)
      3'd0: begin ro_next = s4.v;  go_next = up;    bo_next = s4.lo; end
      3'd1: begin ro_next = dn;    go_next = s4.v;  bo_next = s4.lo; end
      3'd2: begin ro_next = s4.lo; go_next = s4.v;  bo_next = up;    end
      3'd3: begin ro_next = s4.lo; go_next = dn;    bo_next = s4.v;  end
      3'd4: begin ro_next = up;    go_next = s4.lo; bo_next = s4.v;  end
      default: begin ro_next = s4.v; go_next = s4.lo; bo_next = dn; end
    endcase
    if (s4.gray) begin
      ro_next = s4.v;
      go_next = s4.v;
      bo_next = s4.v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= up_valid;
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) vld[k] <= vld[k - 1];
      end
    end
    if (rdy[0] && up_valid) s1 <= s1_next;
    if (rdy[1] && vld[0])   s2 <= s2_next;
    if (rdy[2] && vld[1])   s3 <= s3_next;
    if (rdy[3] && vld[2])   s4 <= s4_next;
    if (rdy[4] && vld[3]) begin
      dst.out_alpha <= s4.alpha;
      dst.out_red   <= ro_next;
      dst.out_green <= go_next;
      dst.out_blue  <= bo_next;
    end
  end

  assign dst.valid = vld[4];

  a_reset_empty: assert property (@(posedge clk) rst |=> !dst.valid)
    else $error("output valid after reset");
  a_low_below_value: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> s4.lo <= s4.v)
    else $error("low channel above value");
  a_ramp_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (s4.ta <= 16'd65025 && s4.tb <= 16'd65025))
    else $error("ramp quotient out of range");
endmodule

// ===== hdl/hsv_value_boost_color.sv =====
// Brightness boost of RGBA words: R,G,B go to 8-bit HSV, V is
// scaled by gain_tenths/10 and clipped at 255, and the color goes back to RGB
// with exact truncating arithmetic. opcode picks the alpha byte (255, alpha_in
// or the word's low byte) or pre-scales the components by 4. Throughput is one
// word per cycle unless dst stalls. One input stage and eight divider cells,
// each settling one quotient bit of saturation and hue, feed five multiply
// and channel-select stages. Write gain_tenths (reset 22) only while idle.
module hsv_value_boost_color (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  hvb_in_if.sink      src,
  hvb_out_if.source   dst
);
  import hvb_pkg::*;

  logic [7:0]  gain;
  logic        cv [NUM_CELLS + 1];
  logic        cr [NUM_CELLS + 1];
  div_word_t   cw [NUM_CELLS + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_we) begin
      gain <= cfg_data;
    end
  end

  hvb_front u_front (
    .clk(clk), .rst(rst), .src(src), .gain(gain),
    .dn_valid(cv[0]), .dn_ready(cr[0]), .dn_word(cw[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    hvb_div_cell u_cell (
      .clk(clk), .rst(rst),
      .up_valid(cv[i]), .up_ready(cr[i]), .up_word(cw[i]),
      .dn_valid(cv[i + 1]), .dn_ready(cr[i + 1]), .dn_word(cw[i + 1])
    );
  end

  hvb_back u_back (
    .clk(clk), .rst(rst),
    .up_valid(cv[NUM_CELLS]), .up_ready(cr[NUM_CELLS]), .up_word(cw[NUM_CELLS]),
    .dst(dst)
  );
endmodule
